// ===== rtl/core/fat12_cluster_chain_walker_defines.svh =====
// Assertion macros used by the checker file fcw_checker.sv.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcw check failed");

// The consequent must hold in the cycle after the antecedent.
`define FCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcw check failed");

`endif

// ===== rtl/core/fcw_pkg.sv =====
package fcw_pkg;

    localparam int FAT_BYTES = 8192;
    localparam int FAT_AW    = $clog2(FAT_BYTES);

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_START   = 2'd1;
    localparam logic [1:0] MODE_ADVANCE = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic [2:0] ST_DATA    = 3'd0;
    localparam logic [2:0] ST_END     = 3'd1;
    localparam logic [2:0] ST_BAD     = 3'd2;
    localparam logic [2:0] ST_LIMIT   = 3'd3;
    localparam logic [2:0] ST_NOCHAIN = 3'd4;

    localparam logic [2:0] REG_BYTES_PER_SECTOR    = 3'd0;
    localparam logic [2:0] REG_SECTORS_PER_CLUSTER = 3'd1;
    localparam logic [2:0] REG_RESERVED_SECTORS    = 3'd2;
    localparam logic [2:0] REG_FAT_COPIES          = 3'd3;
    localparam logic [2:0] REG_SECTORS_PER_FAT     = 3'd4;
    localparam logic [2:0] REG_ROOT_DIR_ENTRIES    = 3'd5;

    localparam logic [11:0] ENTRY_END_MIN = 12'hFF8;
    localparam logic [11:0] ENTRY_BAD     = 12'hFF7;

    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [1:0]  mode;
        logic [12:0] fat_byte_index;
        logic [7:0]  fat_byte_value;
        logic [11:0] start_cluster;
        logic [31:0] file_size;
    } item_t;

    typedef struct packed {
        logic [11:0] cluster;
        logic [31:0] byte_offset;
        logic [2:0]  status;
    } result_t;

    typedef struct packed {
        logic capture;
        logic mem_wr;
        logic rd_lo;
        logic rd_hi;
        logic decode;
        logic mul1;
        logic mul2;
        logic div_step;
        logic emit;
    } ctl_t;

    typedef struct packed {
        logic chain_active;
        logic stop;
    } stat_t;

endpackage

// ===== rtl/core/fcw_datapath.sv =====
module fcw_datapath
    import fcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       item,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  ctl_t        ctl,
    output stat_t       stat,
    output result_t     result
);

    logic [12:0] bps_reg;
    logic [7:0]  spc_reg;
    logic [15:0] res_reg;
    logic [7:0]  copies_reg;
    logic [15:0] spf_reg;
    logic [15:0] rde_reg;

    logic [7:0]  mem [FAT_BYTES];
    logic [7:0]  rdata_reg;
    logic [7:0]  lo_reg;

    item_t       item_reg;
    logic [11:0] clus_op_reg;
    logic [11:0] cur_clus_reg;
    logic [31:0] emitted_reg;
    logic [31:0] limit_reg;
    logic        active_reg;
    logic [2:0]  stop_reg;

    logic [23:0]        t1_reg;
    logic [20:0]        cbytes_reg;
    logic [37:0]        t2_reg;
    logic signed [35:0] t3_reg;
    logic [20:0]        rem_reg;
    logic [31:0]        quo_reg;
    result_t            result_reg;

    logic [12:0]        pos;
    logic [FAT_AW-1:0]  rd_addr;
    logic [FAT_AW-1:0]  wr_addr;
    logic               wr_ok;
    logic [15:0]        word;
    logic [11:0]        entry_next;
    logic [2:0]         stop_next;
    logic [24:0]        bsum;
    logic signed [13:0] clus_m2;
    logic [21:0]        rem_sh;
    logic [21:0]        diff;
    logic               ge;
    logic signed [39:0] sum;
    logic [31:0]        off_sat;
    logic [31:0]        limit_next;

    always_comb
    begin
        pos     = {1'b0, cur_clus_reg} + {2'b00, cur_clus_reg[11:1]};
        rd_addr = ctl.rd_lo ? FAT_AW'(pos) : FAT_AW'(pos + 13'd1);
        wr_addr = FAT_AW'(item_reg.fat_byte_index);
        wr_ok   = 32'(item_reg.fat_byte_index) < 32'(FAT_BYTES);

        word       = {rdata_reg, lo_reg};
        entry_next = cur_clus_reg[0] ? word[15:4] : word[11:0];
        if (entry_next >= ENTRY_END_MIN)
        begin
            stop_next = ST_END;
        end
        else if (entry_next == ENTRY_BAD)
        begin
            stop_next = ST_BAD;
        end
        else if (emitted_reg >= limit_reg)
        begin
            stop_next = ST_LIMIT;
        end
        else
        begin
            stop_next = ST_DATA;
        end

        bsum    = {1'b0, t1_reg} + {9'd0, res_reg};
        clus_m2 = $signed({2'b00, clus_op_reg}) - 14'sd2;

        rem_sh = {rem_reg, quo_reg[31]};
        ge     = rem_sh >= {1'b0, cbytes_reg};
        diff   = rem_sh - {1'b0, cbytes_reg};

        sum = $signed({2'b00, t2_reg}) + $signed({19'd0, rde_reg, 5'd0}) + 40'(t3_reg);
        if (sum < 40'sd0)
        begin
            off_sat = 32'd0;
        end
        else if (sum[39:32] != 8'd0)
        begin
            off_sat = 32'hFFFF_FFFF;
        end
        else
        begin
            off_sat = sum[31:0];
        end

        limit_next = (quo_reg > 32'hFFFF_FFFD) ? 32'hFFFF_FFFF : quo_reg + 32'd2;
    end

    assign stat.chain_active = active_reg;
    assign stat.stop         = (stop_next != ST_DATA);
    assign result            = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg    <= 13'd512;
            spc_reg    <= 8'd1;
            res_reg    <= 16'd1;
            copies_reg <= 8'd2;
            spf_reg    <= 16'd9;
            rde_reg    <= 16'd224;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BYTES_PER_SECTOR:    bps_reg    <= cfg_data[12:0];
                REG_SECTORS_PER_CLUSTER: spc_reg    <= cfg_data[7:0];
                REG_RESERVED_SECTORS:    res_reg    <= cfg_data;
                REG_FAT_COPIES:          copies_reg <= cfg_data[7:0];
                REG_SECTORS_PER_FAT:     spf_reg    <= cfg_data;
                REG_ROOT_DIR_ENTRIES:    rde_reg    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mem_wr && wr_ok)
        begin
            mem[wr_addr] <= item_reg.fat_byte_value;
        end
        if (ctl.rd_lo || ctl.rd_hi)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            item_reg    <= item;
            clus_op_reg <= item.start_cluster;
        end
        if (ctl.rd_hi)
        begin
            lo_reg <= rdata_reg;
        end
        if (ctl.decode)
        begin
            clus_op_reg <= entry_next;
            stop_reg    <= stop_next;
        end
        if (ctl.mul1)
        begin
            t1_reg     <= 24'(copies_reg) * 24'(spf_reg);
            cbytes_reg <= 21'(bps_reg) * 21'(spc_reg);
        end
        if (ctl.mul2)
        begin
            t2_reg  <= 38'(bps_reg) * 38'(bsum);
            t3_reg  <= 36'(clus_m2) * $signed({15'd0, cbytes_reg});
            rem_reg <= 21'd0;
            quo_reg <= item_reg.file_size;
        end
        if (ctl.div_step)
        begin
            rem_reg <= ge ? diff[20:0] : rem_sh[20:0];
            quo_reg <= {quo_reg[30:0], ge};
        end
        if (ctl.emit)
        begin
            if (item_reg.mode == MODE_START)
            begin
                result_reg <= '{cluster: clus_op_reg, byte_offset: off_sat, status: ST_DATA};
            end
            else if (!active_reg)
            begin
                result_reg <= '{cluster: 12'd0, byte_offset: 32'd0, status: ST_NOCHAIN};
            end
            else if (stop_reg != ST_DATA)
            begin
                result_reg <= '{cluster: clus_op_reg, byte_offset: 32'd0, status: stop_reg};
            end
            else
            begin
                result_reg <= '{cluster: clus_op_reg, byte_offset: off_sat, status: ST_DATA};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_clus_reg <= 12'd0;
            emitted_reg  <= 32'd0;
            limit_reg    <= 32'd0;
            active_reg   <= 1'b0;
        end
        else if (ctl.emit)
        begin
            if (item_reg.mode == MODE_START)
            begin
                limit_reg    <= limit_next;
                cur_clus_reg <= clus_op_reg;
                emitted_reg  <= 32'd1;
                active_reg   <= 1'b1;
            end
            else if (active_reg)
            begin
                if (stop_reg != ST_DATA)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    cur_clus_reg <= clus_op_reg;
                    if (emitted_reg != 32'hFFFF_FFFF)
                    begin
                        emitted_reg <= emitted_reg + 32'd1;
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/core/fcw_ctrl.sv =====
module fcw_ctrl
    import fcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] mode,
    input  stat_t      stat,
    output ctl_t       ctl,
    output logic       busy,
    output logic       done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_RD_LO,
        S_RD_HI,
        S_DECODE,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_EMIT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               is_start_reg;
    logic               done_reg;
    logic               accept;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign accept = start && !busy;

    always_comb
    begin
        ctl          = '0;
        ctl.capture  = accept;
        ctl.mem_wr   = (state_reg == S_WRITE);
        ctl.rd_lo    = (state_reg == S_RD_LO);
        ctl.rd_hi    = (state_reg == S_RD_HI);
        ctl.decode   = (state_reg == S_DECODE);
        ctl.mul1     = (state_reg == S_MUL1);
        ctl.mul2     = (state_reg == S_MUL2);
        ctl.div_step = (state_reg == S_DIV);
        ctl.emit     = (state_reg == S_EMIT);

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_LOAD:    state_next = S_WRITE;
                        MODE_START:   state_next = S_MUL1;
                        MODE_ADVANCE: state_next = stat.chain_active ? S_RD_LO : S_EMIT;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_WRITE:  state_next = S_IDLE;
            S_RD_LO:  state_next = S_RD_HI;
            S_RD_HI:  state_next = S_DECODE;
            S_DECODE: state_next = stat.stop ? S_EMIT : S_MUL1;
            S_MUL1:   state_next = S_MUL2;
            S_MUL2:   state_next = is_start_reg ? S_DIV : S_EMIT;
            S_DIV:    state_next = (cnt_reg == CNT_W'(DIV_STEPS - 1)) ? S_EMIT : S_DIV;
            S_EMIT:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            is_start_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EMIT);
            if (accept)
            begin
                is_start_reg <= (mode == MODE_START);
            end
            if (state_reg == S_DIV)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

endmodule

// ===== rtl/core/fat12_cluster_chain_walker.sv =====
// FAT12 cluster chain walker. An item is accepted at a clock edge where start is high
// and busy is low. A load item writes one FAT byte into the internal store and gives no
// result. A start item opens a chain and reports the first cluster with its image byte
// offset; an advance item reads the FAT entry of the current cluster and reports the
// next cluster or the reason the chain ended.
// Each result is shown on result for one cycle with done high; the receiver cannot
// stall it. A start runs both multiply stages and the divider; an advance reads and
// decodes its entry, then multiplies unless the chain stops, or with no chain only
// emits. A load keeps busy high for one cycle. Busy is low while done is shown, so
// the next item may be accepted then. A start is dominated by the radix-2 divider that
// sets the cluster limit, one quotient bit per cycle; an advance by two reads of the
// single-port FAT store and two multiply stages for the offset. Configuration writes
// through cfg_we, cfg_index and cfg_data take effect at once and must be made by the
// user only while the block is idle; the block does not enforce it. Reset returns the
// registers to defaults and closes any chain; the FAT store is undefined until loaded.
module fat12_cluster_chain_walker
    import fcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  item_t       item,
    output logic        busy,
    output logic        done,
    output result_t     result,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    ctl_t  ctl;
    stat_t stat;

    fcw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (item.mode),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    fcw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .stat      (stat),
        .result    (result)
    );

endmodule

// ===== rtl/core/fcw_checker.sv =====
`include "fat12_cluster_chain_walker_defines.svh"

module fcw_checker
    import fcw_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input item_t       item,
    input logic        busy,
    input logic        done,
    input result_t     result
);

    `FCW_ASSERT_NEXT(a_no_back_to_back_done, done, !done)
    `FCW_ASSERT_NEXT(a_accept_sets_busy, start && !busy && item.mode != MODE_UNUSED, busy)
    `FCW_ASSERT_NOW(a_status_known, done, result.status <= ST_NOCHAIN)
    `FCW_ASSERT_NOW(a_stop_has_no_offset, done && result.status != ST_DATA,
        result.byte_offset == 32'd0)
    `FCW_ASSERT_NOW(a_nochain_zero, done && result.status == ST_NOCHAIN,
        result.cluster == 12'd0)

endmodule

bind fat12_cluster_chain_walker fcw_checker u_fcw_checker (.*);

// ===== verif/fat12_cluster_chain_walker_checker.sv =====
`timescale 1ns / 100ps

module fat12_cluster_chain_walker_checker
    import fcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  item_t       item,
    input  logic        done,
    input  result_t     result,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending
);

    logic [7:0]  fat_mem [FAT_BYTES];
    logic [12:0] bytes_per_sector;
    logic [7:0]  sectors_per_cluster;
    logic [15:0] reserved_sectors;
    logic [7:0]  fat_copies;
    logic [15:0] sectors_per_fat;
    logic [15:0] root_dir_entries;
    logic [11:0] cur_cluster;
    logic [31:0] clusters_sent;
    logic [31:0] cluster_cap;
    logic        walking;
    result_t     expected_q [$];
    int          err_cnt = 0;

    function automatic logic [31:0] image_offset(input logic [11:0] clus);
        longint bps;
        longint off;
        bps = longint'(bytes_per_sector);
        off = bps * (longint'(reserved_sectors) + longint'(fat_copies) * longint'(sectors_per_fat))
            + 64'sd32 * longint'(root_dir_entries)
            + (longint'(clus) - 64'sd2) * longint'(sectors_per_cluster) * bps;
        if (off < 0)
            return 32'd0;
        if (off > 64'sh0_FFFF_FFFF)
            return 32'hFFFF_FFFF;
        return off[31:0];
    endfunction

    function automatic logic [11:0] fat_entry(input logic [11:0] clus);
        int          pos;
        logic [15:0] word;
        pos  = (int'(clus) * 3) / 2;
        word = {fat_mem[(pos + 1) % FAT_BYTES], fat_mem[pos % FAT_BYTES]};
        return clus[0] ? word[15:4] : word[11:0];
    endfunction

    task automatic walk_step(input item_t it);
        logic [31:0] cl_bytes;
        logic [31:0] quotient;
        logic [11:0] next;
        result_t     r;
        r = '0;
        case (it.mode)
            MODE_LOAD:
            begin
                fat_mem[it.fat_byte_index] = it.fat_byte_value;
            end
            MODE_START:
            begin
                cl_bytes = 32'(bytes_per_sector) * 32'(sectors_per_cluster);
                quotient = (cl_bytes == 32'd0) ? 32'hFFFF_FFFF : it.file_size / cl_bytes;
                cluster_cap = (quotient > 32'hFFFF_FFFD) ? 32'hFFFF_FFFF : quotient + 32'd2;
                cur_cluster = it.start_cluster;
                clusters_sent = 32'd1;
                walking = 1'b1;
                r.cluster = it.start_cluster;
                r.byte_offset = image_offset(it.start_cluster);
                r.status = ST_DATA;
                expected_q.push_back(r);
            end
            MODE_ADVANCE:
            begin
                if (!walking)
                begin
                    r.status = ST_NOCHAIN;
                end
                else
                begin
                    next = fat_entry(cur_cluster);
                    r.cluster = next;
                    if (next >= ENTRY_END_MIN)
                    begin
                        walking = 1'b0;
                        r.status = ST_END;
                    end
                    else if (next == ENTRY_BAD)
                    begin
                        walking = 1'b0;
                        r.status = ST_BAD;
                    end
                    else if (clusters_sent >= cluster_cap)
                    begin
                        walking = 1'b0;
                        r.status = ST_LIMIT;
                    end
                    else
                    begin
                        cur_cluster = next;
                        if (clusters_sent != 32'hFFFF_FFFF)
                            clusters_sent = clusters_sent + 32'd1;
                        r.byte_offset = image_offset(next);
                        r.status = ST_DATA;
                    end
                end
                expected_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            bytes_per_sector = 13'd512;
            sectors_per_cluster = 8'd1;
            reserved_sectors = 16'd1;
            fat_copies = 8'd2;
            sectors_per_fat = 16'd9;
            root_dir_entries = 16'd224;
            cur_cluster = '0;
            clusters_sent = '0;
            cluster_cap = '0;
            walking = 1'b0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BYTES_PER_SECTOR:    bytes_per_sector = cfg_data[12:0];
                    REG_SECTORS_PER_CLUSTER: sectors_per_cluster = cfg_data[7:0];
                    REG_RESERVED_SECTORS:    reserved_sectors = cfg_data;
                    REG_FAT_COPIES:          fat_copies = cfg_data[7:0];
                    REG_SECTORS_PER_FAT:     sectors_per_fat = cfg_data;
                    REG_ROOT_DIR_ENTRIES:    root_dir_entries = cfg_data;
                    default: ;
                endcase
            end
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    err_cnt++;
                    $error("unexpected result: cluster %0h, byte_offset %0h, status %0d",
                           result.cluster, result.byte_offset, result.status);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result.cluster !== want.cluster)
                    begin
                        err_cnt++;
                        $error("cluster: expected %0h, actual %0h",
                               want.cluster, result.cluster);
                    end
                    if (result.byte_offset !== want.byte_offset)
                    begin
                        err_cnt++;
                        $error("byte_offset: expected %0h, actual %0h",
                               want.byte_offset, result.byte_offset);
                    end
                    if (result.status !== want.status)
                    begin
                        err_cnt++;
                        $error("status: expected %0d, actual %0d",
                               want.status, result.status);
                    end
                end
            end
            if (start && !busy)
                walk_step(item);
        end
        errors <= err_cnt;
        pending <= expected_q.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import fcw_pkg::*;

    localparam logic [2:0] REG_SPARE_LO  = 3'd6;
    localparam logic [2:0] REG_SPARE_HI  = 3'd7;
    localparam int FAT_READ_SPAN = 6144;
    localparam int PHASE_ITEMS   = 260;
    localparam int PHASES        = 7;
    localparam int DRAIN_CYCLES  = 48;
    localparam int STALL_LIMIT   = 1000;

    logic        clk;
    logic        rst_n;
    logic        start;
    item_t       item;
    logic        busy;
    logic        done;
    result_t     result;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;

    bit [7:0]    fat_image [FAT_READ_SPAN];
    logic [11:0] linked_q [$];
    logic [12:0] sector_bytes = 13'd512;
    logic [7:0]  cluster_sectors = 8'd1;
    bit          steady = 1'b0;
    int          sent = 0;
    int          stall_cycles = 0;

    fat12_cluster_chain_walker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fat12_cluster_chain_walker_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic item_t scrambled_item(input logic [1:0] mode);
        item_t it;
        it.mode = mode;
        it.fat_byte_index = 13'($urandom);
        it.fat_byte_value = 8'($urandom);
        it.start_cluster = 12'($urandom);
        it.file_size = $urandom;
        return it;
    endfunction

    task automatic issue(input item_t it);
        int gap;
        if ($urandom_range(0, 39) == 0)
            steady = !steady;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        sent++;
    endtask

    task automatic load_byte(input int idx, input logic [7:0] val);
        item_t it;
        it = scrambled_item(MODE_LOAD);
        it.fat_byte_index = 13'(idx);
        it.fat_byte_value = val;
        issue(it);
    endtask

    // Neighboring entries share a byte, so the untouched nibble is kept from the image.
    task automatic set_entry(input logic [11:0] clus, input logic [11:0] val);
        int pos;
        pos = (int'(clus) * 3) / 2;
        if (!clus[0])
        begin
            fat_image[pos] = val[7:0];
            fat_image[pos + 1] = {fat_image[pos + 1][7:4], val[11:8]};
        end
        else
        begin
            fat_image[pos] = {val[3:0], fat_image[pos][3:0]};
            fat_image[pos + 1] = val[11:4];
        end
        load_byte(pos, fat_image[pos]);
        load_byte(pos + 1, fat_image[pos + 1]);
        linked_q.push_back(clus);
    endtask

    task automatic open_chain(input logic [11:0] clus, input logic [31:0] size);
        item_t it;
        it = scrambled_item(MODE_START);
        it.start_cluster = clus;
        it.file_size = size;
        issue(it);
    endtask

    task automatic advance_chain();
        issue(scrambled_item(MODE_ADVANCE));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == REG_BYTES_PER_SECTOR)
            sector_bytes = val[12:0];
        if (idx == REG_SECTORS_PER_CLUSTER)
            cluster_sectors = val[7:0];
    endtask

    task automatic configure(input int phase);
        logic [15:0] v [6];
        case (phase)
            1: v = '{16'd512, 16'd4, 16'd1, 16'd2, 16'd9, 16'd224};
            2: v = '{default: 16'd0};
            3: v = '{16'd1, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0};
            4: v = '{default: 16'hFFFF};
            5: v = '{16'd4096, 16'd128, 16'd65535, 16'd255, 16'd65535, 16'd65535};
            default: foreach (v[i]) v[i] = 16'($urandom);
        endcase
        write_reg(REG_BYTES_PER_SECTOR, v[0]);
        write_reg(REG_SECTORS_PER_CLUSTER, v[1]);
        write_reg(REG_RESERVED_SECTORS, v[2]);
        write_reg(REG_FAT_COPIES, v[3]);
        write_reg(REG_SECTORS_PER_FAT, v[4]);
        write_reg(REG_ROOT_DIR_ENTRIES, v[5]);
        if (phase > 5)
        begin
            write_reg(REG_SPARE_LO, 16'($urandom));
            write_reg(REG_SPARE_HI, 16'($urandom));
        end
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Entries are written before the chain is opened; each link but the last marker points
    // at a cluster whose entry is also written, so no walk reads an unloaded byte.
    task automatic run_chain();
        logic [11:0] links [$];
        logic [31:0] cl_bytes;
        logic [31:0] size;
        int          n;
        int          steps;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        links.push_back(12'($urandom));
        for (int i = 1; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                links.push_back(links[$urandom_range(0, i - 1)]);
            else
                links.push_back(12'($urandom_range(0, ENTRY_BAD - 12'd1)));
        end
        for (int i = n - 1; i >= 0; i--)
            set_entry(links[i], (i == n - 1) ? 12'($urandom_range(ENTRY_BAD, 12'hFFF))
                                             : links[i + 1]);
        cl_bytes = 32'(sector_bytes) * 32'(cluster_sectors);
        case ($urandom_range(0, 5))
            0: size = $urandom;
            1: size = 32'hFFFF_FFFF - 32'($urandom_range(0, 1));
            2: size = 32'd0;
            default: size = (cl_bytes == 32'd0) ? $urandom
                          : cl_bytes * 32'($urandom_range(0, n + 1)) + $urandom % cl_bytes;
        endcase
        open_chain(links[0], size);
        steps = ($urandom_range(0, 3) != 0) ? n + 1 : $urandom_range(0, n + 2);
        repeat (steps) advance_chain();
    endtask

    task automatic random_step();
        if ($urandom_range(0, 9) < 8)
        begin
            run_chain();
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: advance_chain();
                1: issue(scrambled_item(MODE_UNUSED));
                2: load_byte($urandom_range(FAT_READ_SPAN, FAT_BYTES - 1), 8'($urandom));
                default:
                begin
                    if (linked_q.size() != 0)
                        open_chain(linked_q[$urandom_range(0, linked_q.size() - 1)], $urandom);
                    else
                        advance_chain();
                end
            endcase
        end
    endtask

    task automatic directed_items();
        item_t it;
        advance_chain();
        issue(scrambled_item(MODE_UNUSED));
        it = '1;
        issue(it);
        open_chain(12'd0, 32'd0);
        set_entry(12'd4, ENTRY_END_MIN);
        set_entry(12'd3, 12'd4);
        set_entry(12'd2, 12'd3);
        open_chain(12'd2, 32'd0);
        advance_chain();
        advance_chain();
        open_chain(12'd3, 32'hFFFF_FFFF);
        advance_chain();
        advance_chain();
        set_entry(12'hFFF, ENTRY_BAD);
        open_chain(12'hFFF, 32'hFFFF_FFFF);
        advance_chain();
    endtask

    initial
    begin
        int target;
        rst_n <= 1'b0;
        start <= 1'b0;
        item <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        for (int phase = 1; phase <= PHASES; phase++)
        begin
            drain();
            configure(phase);
            target = sent + PHASE_ITEMS;
            while (sent < target)
                random_step();
        end
        drain();
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
